// File: hw/rtl/bgt_pkg.sv
// Package with the shared types, constants and helper functions of the grid thinning block.
`default_nettype none
package bgt_pkg;

    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 256;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_RUN  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [2:0] CFG_METHOD    = 3'd0;
    localparam logic [2:0] CFG_COMPARE   = 3'd1;
    localparam logic [2:0] CFG_THRESHOLD = 3'd2;
    localparam logic [2:0] CFG_COLS      = 3'd3;
    localparam logic [2:0] CFG_ROWS      = 3'd4;

    localparam logic [1:0] CLASS_BACK = 2'd0;
    localparam logic [1:0] CLASS_FORE = 2'd1;
    localparam logic [1:0] CLASS_SKEL = 2'd2;

    localparam logic [7:0] TMPL_OFF [8] = '{8'h83, 8'h07, 8'h0E, 8'h1C,
                                            8'h38, 8'h70, 8'hE0, 8'hC1};
    localparam logic [7:0] TMPL_ON  [8] = '{8'h38, 8'h50, 8'hE0, 8'h41,
                                            8'h83, 8'h05, 8'h0E, 8'h14};

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        cell_index;
        logic signed [15:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  cell_class;
        logic [15:0] rounds;
        logic [1:0]  cmd_echo;
    } t_out_item;

    typedef struct packed {
        logic       method;
        logic       crossing_phase;
        logic [2:0] dir;
        logic       center;
        logic       center_cross1;
        logic [7:0] nb;
        logic [7:0] cross1;
    } t_eval_in;

    typedef struct packed {
        logic       remove;
        logic [2:0] crossings;
    } t_eval_out;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] k;
        k = '0;
        for (int i = 0; i < 8; i++) begin
            k = k + 4'(v[i]);
        end
        return k;
    endfunction

    function automatic logic [3:0] crossing_count(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(!v[(i + 7) % 8] && v[i]);
        end
        return n;
    endfunction

    function automatic logic hilditch_ok(input logic [7:0] nb, input logic [7:0] c1,
                                         input logic [2:0] d0);
        logic [2:0] d2;
        logic [2:0] d4;
        logic [2:0] d6;
        logic       ok;
        d2 = d0 + 3'd2;
        d4 = d0 + 3'd4;
        d6 = d0 + 3'd6;
        ok = 1'b1;
        if ((nb[d0] || nb[d2] || nb[d6]) && c1[d0]) ok = 1'b0;
        if ((nb[d0] || nb[d2] || nb[d4]) && c1[d2]) ok = 1'b0;
        return ok;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/binary_grid_thinning.sv
// Top level of the binary grid thinning block with its cell memories and sequencer.
`default_nettype none
// Load, read and unknown commands answer in the cycle after the transfer;
// they can follow back to back. A run command holds busy high while it copies the foreground
// and then thins in rounds; every scan of the grid reads, for each cell, the eight neighbors
// and the cell itself one per cycle from the single read port of the cell memory. A template
// round is eight scans, a Hilditch round two. The result of every command appears for one
// cycle with o_strobe and cannot be held off by the receiver.
module binary_grid_thinning #(
    parameter int MAX_COLS = bgt_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = bgt_pkg::DEF_MAX_ROWS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire bgt_pkg::t_in_item i_item,
    output logic                 o_strobe,
    output bgt_pkg::t_out_item   o_result,
    input  wire                  i_cfg_we,
    input  wire [2:0]            i_cfg_idx,
    input  wire [15:0]           i_cfg_wdata
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CIW   = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_COPY = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [2:0] mem_cell [DEPTH];
    logic [2:0] mem_cross [DEPTH];

    logic               r_method;
    logic               r_cmp;
    logic signed [15:0] r_thr;
    logic [8:0]         r_cols;
    logic [8:0]         r_rows;

    logic [1:0]     r_state;
    logic           r_bank;
    logic [2:0]     r_dir;
    logic           r_hph;
    logic           r_any;
    logic [15:0]    r_rounds;
    logic [3:0]     r_k;
    logic [RIW-1:0] r_row;
    logic [CIW-1:0] r_col;
    logic [AW-1:0]  r_addr;
    logic [NW-1:0]  r_cnt;
    logic           r_cp_v;
    logic [AW-1:0]  r_cp_addr;
    logic           r_oob_d;
    logic [7:0]     r_nb;
    logic [7:0]     r_c1;
    logic           r_ctr;
    logic           r_cc1;
    logic           r_res_v;
    logic [1:0]     r_res_cmd;
    logic           r_res_inr;
    logic [2:0]     r_m1_q;
    logic [2:0]     r_cr_q;

    logic [RW-1:0] rows_c;
    logic [CW-1:0] cols_c;
    logic [NW-1:0] n_cells;
    logic          accept;
    logic          in_range;
    logic          fg_new;
    logic          last_row;
    logic          last_col;
    logic          first_row;
    logic          first_col;
    logic          last_cell;
    logic [AW-1:0] cols_a;
    logic [AW-1:0] nbr_addr;
    logic          nbr_oob;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] w_addr;
    logic [1:0]    w_bit;
    logic          w_val;
    logic          src_bit;
    logic          cross_we;
    logic          any_next;

    bgt_pkg::t_eval_in  ev_in;
    bgt_pkg::t_eval_out ev_out;

    bgt_eval u_eval (
        .i_eval (ev_in),
        .o_eval (ev_out)
    );

    always_comb begin
        if (r_rows == 9'd0) begin
            rows_c = RW'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            rows_c = RW'(MAX_ROWS);
        end else begin
            rows_c = RW'(r_rows);
        end
        if (r_cols == 9'd0) begin
            cols_c = CW'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            cols_c = CW'(MAX_COLS);
        end else begin
            cols_c = CW'(r_cols);
        end
        n_cells = NW'(rows_c * cols_c);
    end

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(i_item.cell_index) < 32'(n_cells));
    assign fg_new   = r_cmp ? (i_item.sample > r_thr) : (i_item.sample < r_thr);

    assign last_row  = (32'(r_row) + 32'd1 == 32'(rows_c));
    assign last_col  = (32'(r_col) + 32'd1 == 32'(cols_c));
    assign first_row = (r_row == '0);
    assign first_col = (r_col == '0);
    assign last_cell = last_row && last_col;
    assign cols_a    = AW'(cols_c);
    assign src_bit   = r_bank ? r_m1_q[2] : r_m1_q[1];

    always_comb begin
        unique case (r_k)
            4'd0: begin
                nbr_addr = r_addr + cols_a;
                nbr_oob  = last_row;
            end
            4'd1: begin
                nbr_addr = r_addr + cols_a + AW'(1);
                nbr_oob  = last_row || last_col;
            end
            4'd2: begin
                nbr_addr = r_addr + AW'(1);
                nbr_oob  = last_col;
            end
            4'd3: begin
                nbr_addr = r_addr - cols_a + AW'(1);
                nbr_oob  = first_row || last_col;
            end
            4'd4: begin
                nbr_addr = r_addr - cols_a;
                nbr_oob  = first_row;
            end
            4'd5: begin
                nbr_addr = r_addr - cols_a - AW'(1);
                nbr_oob  = first_row || first_col;
            end
            4'd6: begin
                nbr_addr = r_addr - AW'(1);
                nbr_oob  = first_col;
            end
            4'd7: begin
                nbr_addr = r_addr + cols_a - AW'(1);
                nbr_oob  = last_row || first_col;
            end
            default: begin
                nbr_addr = r_addr;
                nbr_oob  = 1'b0;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_COPY:  rd_addr = AW'(r_cnt);
            S_SCAN:  rd_addr = nbr_addr;
            default: rd_addr = AW'(i_item.cell_index);
        endcase
    end

    always_comb begin
        ev_in.method         = r_method;
        ev_in.crossing_phase = !r_hph;
        ev_in.dir            = r_dir;
        ev_in.center         = r_ctr;
        ev_in.center_cross1  = r_cc1;
        ev_in.nb             = r_nb;
        ev_in.cross1         = r_c1;
    end

    assign cross_we = (r_state == S_SCAN) && (r_k == 4'd10) && r_method && !r_hph;
    assign any_next = r_any || ev_out.remove;

    always_comb begin
        we     = 1'b0;
        w_addr = r_addr;
        w_bit  = 2'd0;
        w_val  = 1'b0;
        priority if (r_cp_v) begin
            we     = 1'b1;
            w_addr = r_cp_addr;
            w_bit  = 2'd1 + {1'b0, r_bank};
            w_val  = r_m1_q[0];
        end else if ((r_state == S_SCAN) && (r_k == 4'd10) && !cross_we) begin
            we     = 1'b1;
            w_addr = r_addr;
            w_bit  = 2'd1 + {1'b0, !r_bank};
            w_val  = r_ctr && !ev_out.remove;
        end else if (accept && (i_item.cmd == bgt_pkg::CMD_LOAD) && in_range) begin
            we     = 1'b1;
            w_addr = AW'(i_item.cell_index);
            w_bit  = 2'd0;
            w_val  = fg_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_cell[w_addr][w_bit] <= w_val;
        end
        if (cross_we) begin
            mem_cross[r_addr] <= ev_out.crossings;
        end
        r_m1_q <= mem_cell[rd_addr];
        r_cr_q <= mem_cross[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method  <= 1'b0;
            r_cmp     <= 1'b1;
            r_thr     <= '0;
            r_cols    <= 9'd256;
            r_rows    <= 9'd256;
            r_state   <= S_IDLE;
            r_bank    <= 1'b0;
            r_dir     <= '0;
            r_hph     <= 1'b0;
            r_any     <= 1'b0;
            r_rounds  <= '0;
            r_k       <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_addr    <= '0;
            r_cnt     <= '0;
            r_cp_v    <= 1'b0;
            r_res_v   <= 1'b0;
            r_res_cmd <= '0;
            r_res_inr <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bgt_pkg::CFG_METHOD:    r_method <= i_cfg_wdata[0];
                    bgt_pkg::CFG_COMPARE:   r_cmp    <= i_cfg_wdata[0];
                    bgt_pkg::CFG_THRESHOLD: r_thr    <= i_cfg_wdata;
                    bgt_pkg::CFG_COLS:      r_cols   <= i_cfg_wdata[8:0];
                    bgt_pkg::CFG_ROWS:      r_rows   <= i_cfg_wdata[8:0];
                    default: ;
                endcase
            end
            r_res_v <= 1'b0;
            r_cp_v  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_cmd <= i_item.cmd;
                        r_res_inr <= in_range;
                        if (i_item.cmd == bgt_pkg::CMD_RUN) begin
                            r_state  <= S_COPY;
                            r_cnt    <= '0;
                            r_rounds <= 16'd1;
                            r_any    <= 1'b0;
                            r_dir    <= '0;
                            r_hph    <= 1'b0;
                            r_k      <= '0;
                            r_row    <= '0;
                            r_col    <= '0;
                            r_addr   <= '0;
                        end else begin
                            r_res_v <= 1'b1;
                        end
                    end
                end
                S_COPY: begin
                    if (r_cnt < n_cells) begin
                        r_cp_v    <= 1'b1;
                        r_cp_addr <= AW'(r_cnt);
                        r_cnt     <= r_cnt + NW'(1);
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_oob_d <= nbr_oob;
                    if (r_k != 4'd10) begin
                        r_k <= r_k + 4'd1;
                    end
                    if ((r_k >= 4'd1) && (r_k <= 4'd8)) begin
                        r_nb[3'(r_k - 4'd1)] <= !r_oob_d && src_bit;
                        r_c1[3'(r_k - 4'd1)] <= !r_oob_d && (r_cr_q == 3'd1);
                    end
                    if (r_k == 4'd9) begin
                        r_ctr <= src_bit;
                        r_cc1 <= (r_cr_q == 3'd1);
                    end
                    if (r_k == 4'd10) begin
                        r_k   <= '0;
                        r_any <= any_next;
                        if (!last_cell) begin
                            r_addr <= r_addr + AW'(1);
                            if (last_col) begin
                                r_col <= '0;
                                r_row <= r_row + RIW'(1);
                            end else begin
                                r_col <= r_col + CIW'(1);
                            end
                        end else begin
                            r_addr <= '0;
                            r_row  <= '0;
                            r_col  <= '0;
                            if (r_method && !r_hph) begin
                                r_hph <= 1'b1;
                            end else begin
                                r_bank <= !r_bank;
                                r_hph  <= 1'b0;
                                r_dir  <= r_dir + 3'd1;
                                if (r_method || (r_dir == 3'd7)) begin
                                    r_dir <= '0;
                                    r_any <= 1'b0;
                                    if (!any_next) begin
                                        // The last round changed nothing, so bank zero
                                        // already holds the final skeleton.
                                        r_bank    <= 1'b0;
                                        r_state   <= S_IDLE;
                                        r_res_v   <= 1'b1;
                                        r_res_cmd <= bgt_pkg::CMD_RUN;
                                    end else if (r_rounds != 16'hFFFF) begin
                                        r_rounds <= r_rounds + 16'd1;
                                    end
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_strobe            = r_res_v;
        o_result.cmd_echo   = r_res_cmd;
        o_result.rounds     = (r_res_cmd == bgt_pkg::CMD_RUN) ? r_rounds : 16'd0;
        o_result.cell_class = bgt_pkg::CLASS_BACK;
        if ((r_res_cmd == bgt_pkg::CMD_READ) && r_res_inr && r_m1_q[0]) begin
            o_result.cell_class = src_bit ? bgt_pkg::CLASS_SKEL : bgt_pkg::CLASS_FORE;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/bgt_eval.sv
// Per-cell decision logic: template removal, Hilditch removal and crossing number.
`default_nettype none
module bgt_eval (
    input  wire bgt_pkg::t_eval_in  i_eval,
    output bgt_pkg::t_eval_out      o_eval
);

    logic [3:0] k;
    logic [3:0] xn;
    logic       tmpl_rm;
    logic       hil_rm;

    always_comb begin
        k  = bgt_pkg::popcount8(i_eval.nb);
        xn = bgt_pkg::crossing_count(i_eval.nb);
        tmpl_rm = i_eval.center && (k > 4'd1) && (k < 4'd6)
            && ((i_eval.nb & bgt_pkg::TMPL_OFF[i_eval.dir]) == 8'h00)
            && ((i_eval.nb & bgt_pkg::TMPL_ON[i_eval.dir]) == bgt_pkg::TMPL_ON[i_eval.dir]);
        hil_rm = i_eval.center && (k >= 4'd2) && (k <= 4'd6) && i_eval.center_cross1
            && (bgt_pkg::hilditch_ok(i_eval.nb, i_eval.cross1, 3'd0)
             || bgt_pkg::hilditch_ok(i_eval.nb, i_eval.cross1, 3'd2)
             || bgt_pkg::hilditch_ok(i_eval.nb, i_eval.cross1, 3'd4)
             || bgt_pkg::hilditch_ok(i_eval.nb, i_eval.cross1, 3'd6));
        if (i_eval.method) begin
            o_eval.remove = !i_eval.crossing_phase && hil_rm;
        end else begin
            o_eval.remove = tmpl_rm;
        end
        o_eval.crossings = i_eval.center ? xn[2:0] : 3'd0;
    end

endmodule
`default_nettype wire

// File: verif/binary_grid_thinning_test.sv
// Testbench for binary_grid_thinning: random command streams checked against a thinning predictor.
`timescale 1ns / 1ps
module binary_grid_thinning_test;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int STEP_COL [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
    localparam int STEP_ROW [8] = '{1, 1, 0, -1, -1, -1, 0, 1};

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    bgt_pkg::t_in_item   i_item = '0;
    logic       o_strobe;
    bgt_pkg::t_out_item  o_result;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;

    int mismatches = 0;
    int cycles = 0;
    int idle_pct = 0;
    int items_sent = 0;

    binary_grid_thinning u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        mismatches++;
    endtask

    class thin_scoreboard;
        bit          fg [65536];
        bit          skel [65536];
        bit          work [65536];
        logic [2:0]  xmap [65536];
        bit          fg_known [65536];
        bit          skel_known [65536];
        bit          method = 1'b0;
        bit          cmp_above = 1'b1;
        logic signed [15:0] thr = '0;
        logic [8:0]  cols_reg = 9'd256;
        logic [8:0]  rows_reg = 9'd256;
        bgt_pkg::t_out_item expected_q [$];

        function int ncols();
            return (cols_reg < 1) ? 1 : (cols_reg > 256) ? 256 : int'(cols_reg);
        endfunction

        function int nrows();
            return (rows_reg < 1) ? 1 : (rows_reg > 256) ? 256 : int'(rows_reg);
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [15:0] val);
            case (idx)
                bgt_pkg::CFG_METHOD:    method = val[0];
                bgt_pkg::CFG_COMPARE:   cmp_above = val[0];
                bgt_pkg::CFG_THRESHOLD: thr = val;
                bgt_pkg::CFG_COLS:      cols_reg = val[8:0];
                bgt_pkg::CFG_ROWS:      rows_reg = val[8:0];
                default: ;
            endcase
        endfunction

        function bit skel_at(input int r, input int c);
            if (r < 0 || c < 0 || r >= nrows() || c >= ncols()) return 1'b0;
            return skel[r * ncols() + c];
        endfunction

        function bit cross_one(input int r, input int c);
            if (r < 0 || c < 0 || r >= nrows() || c >= ncols()) return 1'b0;
            return xmap[r * ncols() + c] == 3'd1;
        endfunction

        function logic [7:0] neighbors(input int r, input int c);
            logic [7:0] nb;
            nb = '0;
            for (int i = 0; i < 8; i++) nb[i] = skel_at(r + STEP_ROW[i], c + STEP_COL[i]);
            return nb;
        endfunction

        function int ones(input logic [7:0] v);
            int k;
            k = 0;
            for (int i = 0; i < 8; i++) k += v[i];
            return k;
        endfunction

        function int transitions(input logic [7:0] v);
            int n;
            n = 0;
            for (int i = 0; i < 8; i++) if (!v[(i + 7) % 8] && v[i]) n++;
            return n;
        endfunction

        function bit side_clear(input logic [7:0] nb, input int r, input int c, input int d0);
            int d2;
            int d4;
            int d6;
            d2 = (d0 + 2) % 8;
            d4 = (d0 + 4) % 8;
            d6 = (d0 + 6) % 8;
            if ((nb[d0] || nb[d2] || nb[d6]) && cross_one(r + STEP_ROW[d0], c + STEP_COL[d0]))
                return 1'b0;
            if ((nb[d0] || nb[d2] || nb[d4]) && cross_one(r + STEP_ROW[d2], c + STEP_COL[d2]))
                return 1'b0;
            return 1'b1;
        endfunction

        function int thin_scan(input int dir, input bit hilditch);
            int removed;
            int k;
            logic [7:0] nb;
            removed = 0;
            if (hilditch) begin
                for (int r = 0; r < nrows(); r++)
                    for (int c = 0; c < ncols(); c++) begin
                        nb = neighbors(r, c);
                        xmap[r * ncols() + c] = (skel[r * ncols() + c] && nb != 0) ?
                                                3'(transitions(nb)) : 3'd0;
                    end
            end
            for (int r = 0; r < nrows(); r++)
                for (int c = 0; c < ncols(); c++) begin
                    work[r * ncols() + c] = skel[r * ncols() + c];
                    if (skel[r * ncols() + c]) begin
                        nb = neighbors(r, c);
                        k = ones(nb);
                        if (!hilditch && k > 1 && k < 6 &&
                            (nb & bgt_pkg::TMPL_OFF[dir]) == 0 &&
                            (nb & bgt_pkg::TMPL_ON[dir]) == bgt_pkg::TMPL_ON[dir]) begin
                            work[r * ncols() + c] = 1'b0;
                            removed++;
                        end
                        if (hilditch && k >= 2 && k <= 6 && xmap[r * ncols() + c] == 3'd1 &&
                            (side_clear(nb, r, c, 0) || side_clear(nb, r, c, 2) ||
                             side_clear(nb, r, c, 4) || side_clear(nb, r, c, 6))) begin
                            work[r * ncols() + c] = 1'b0;
                            removed++;
                        end
                    end
                end
            for (int i = 0; i < nrows() * ncols(); i++) skel[i] = work[i];
            return removed;
        endfunction

        function logic [15:0] thin_grid();
            int rounds;
            int removed;
            rounds = 0;
            for (int i = 0; i < nrows() * ncols(); i++) begin
                skel[i] = fg[i];
                skel_known[i] = 1'b1;
            end
            do begin
                rounds++;
                removed = 0;
                if (method) removed = thin_scan(0, 1'b1);
                else for (int d = 0; d < 8; d++) removed += thin_scan(d, 1'b0);
            end while (removed > 0);
            return (rounds > 65535) ? 16'hFFFF : 16'(rounds);
        endfunction

        function bit readable(input int idx);
            if (idx >= nrows() * ncols()) return 1'b1;
            return fg_known[idx] && (!fg[idx] || skel_known[idx]);
        endfunction

        function void note_input(input bgt_pkg::t_in_item it);
            bgt_pkg::t_out_item res;
            int idx;
            idx = int'(it.cell_index);
            res = '0;
            res.cmd_echo = it.cmd;
            if (it.cmd == bgt_pkg::CMD_LOAD) begin
                if (idx < nrows() * ncols()) begin
                    fg[idx] = cmp_above ? (it.sample > thr) : (it.sample < thr);
                    fg_known[idx] = 1'b1;
                end
            end else if (it.cmd == bgt_pkg::CMD_RUN) begin
                res.rounds = thin_grid();
            end else if (it.cmd == bgt_pkg::CMD_READ) begin
                if (idx < nrows() * ncols() && fg[idx])
                    res.cell_class = skel[idx] ? bgt_pkg::CLASS_SKEL : bgt_pkg::CLASS_FORE;
            end
            expected_q.push_back(res);
        endfunction

        task check_result(input bgt_pkg::t_out_item got);
            bgt_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                report("unexpected result, cmd_echo", got.cmd_echo, -1);
                return;
            end
            want = expected_q.pop_front();
            if (got.cmd_echo !== want.cmd_echo) report("cmd_echo", got.cmd_echo, want.cmd_echo);
            if (got.cell_class !== want.cell_class)
                report("cell_class", got.cell_class, want.cell_class);
            if (got.rounds !== want.rounds) report("rounds", got.rounds, want.rounds);
        endtask
    endclass

    thin_scoreboard sb = new();

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_result);
    end

    task automatic send(input logic [1:0] cmd, input int idx, input int smp);
        bgt_pkg::t_in_item it;
        it.cmd = cmd;
        it.cell_index = 16'(idx);
        it.sample = 16'(smp);
        i_cfg_we <= 1'b0;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0 || busy);
        repeat (8) @(posedge i_clk);
    endtask

    // The write enable is dropped by the next transfer that send drives.
    task automatic write_reg(input logic [2:0] idx, input int val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= 16'(val);
        @(posedge i_clk);
        sb.set_reg(idx, 16'(val));
    endtask

    function automatic int pick_sample(input int density);
        int t;
        t = int'(sb.thr);
        if ($urandom_range(99) >= density) return int'($urandom_range(65535)) - 32768;
        if (sb.cmp_above && t < 32767) return t + 1 + int'($urandom_range(32766 - t));
        if (!sb.cmp_above && t > -32768) return t - 1 - int'($urandom_range(t + 32767));
        return t;
    endfunction

    task automatic read_random();
        int idx;
        idx = int'($urandom_range(sb.nrows() * sb.ncols() - 1));
        if ($urandom_range(7) == 0 || !sb.readable(idx)) idx = int'($urandom_range(65535));
        if (!sb.readable(idx)) idx = sb.nrows() * sb.ncols() + int'($urandom_range(3));
        if (sb.readable(idx)) send(bgt_pkg::CMD_READ, idx, int'($urandom_range(65535)));
    endtask

    task automatic grid_session();
        int sel;
        int n;
        int density;
        settle();
        sel = $urandom_range(19);
        write_reg(bgt_pkg::CFG_METHOD, $urandom_range(1));
        write_reg(bgt_pkg::CFG_COMPARE, $urandom_range(1));
        case ($urandom_range(5))
            0: write_reg(bgt_pkg::CFG_THRESHOLD, 32767);
            1: write_reg(bgt_pkg::CFG_THRESHOLD, -32768);
            default: write_reg(bgt_pkg::CFG_THRESHOLD, int'($urandom_range(65535)));
        endcase
        if (sel == 0) begin
            write_reg(bgt_pkg::CFG_COLS, $urandom_range(1) ? 256 : 511);
            write_reg(bgt_pkg::CFG_ROWS, 1);
        end else if (sel == 1) begin
            write_reg(bgt_pkg::CFG_COLS, 0);
            write_reg(bgt_pkg::CFG_ROWS, $urandom_range(1) ? 256 : 300);
        end else if (sel == 2) begin
            write_reg(bgt_pkg::CFG_COLS, 0);
            write_reg(bgt_pkg::CFG_ROWS, 0);
        end else begin
            write_reg(bgt_pkg::CFG_COLS, $urandom_range(8, 2));
            write_reg(bgt_pkg::CFG_ROWS, $urandom_range(8, 2));
        end
        n = sb.nrows() * sb.ncols();
        density = $urandom_range(1) ? 85 : 50;
        for (int i = 0; i < n; i++) send(bgt_pkg::CMD_LOAD, i, pick_sample(density));
        repeat ($urandom_range(20, 8)) begin
            case ($urandom_range(9))
                0, 1, 2: send(bgt_pkg::CMD_LOAD, $urandom_range(n - 1), pick_sample(density));
                3: send(bgt_pkg::CMD_LOAD, $urandom_range(65535), pick_sample(density));
                4: send(2'd3, $urandom_range(65535), int'($urandom_range(65535)));
                default: read_random();
            endcase
        end
        send(bgt_pkg::CMD_RUN, $urandom_range(65535), int'($urandom_range(65535)));
        repeat ($urandom_range(14, 6)) read_random();
        if ($urandom_range(3) == 0) begin
            send(bgt_pkg::CMD_LOAD, $urandom_range(n - 1), pick_sample(density));
            send(bgt_pkg::CMD_RUN, 0, 0);
            repeat (4) read_random();
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        idle_pct = 15;
        send(bgt_pkg::CMD_LOAD, 0, 32767);
        send(bgt_pkg::CMD_LOAD, 65535, -32768);
        send(bgt_pkg::CMD_READ, 65535, 0);
        send(2'd3, 65535, -1);
        settle();
        write_reg(bgt_pkg::CFG_COLS, 3);
        write_reg(bgt_pkg::CFG_ROWS, 3);
        for (int i = 0; i < 9; i++) send(bgt_pkg::CMD_LOAD, i, (i == 0 || i == 8) ? -5 : 100 + i);
        send(bgt_pkg::CMD_LOAD, 9, 1);
        send(bgt_pkg::CMD_READ, 9, 0);
        send(bgt_pkg::CMD_RUN, 0, 0);
        send(bgt_pkg::CMD_READ, 4, 0);
        send(bgt_pkg::CMD_READ, 0, 0);
        settle();
        write_reg(bgt_pkg::CFG_METHOD, 1);
        write_reg(bgt_pkg::CFG_COMPARE, 0);
        write_reg(bgt_pkg::CFG_THRESHOLD, 32767);
        send(bgt_pkg::CMD_RUN, 0, 0);
        send(bgt_pkg::CMD_READ, 1, 0);
        send(bgt_pkg::CMD_LOAD, 4, 32767);
        send(bgt_pkg::CMD_RUN, 0, 0);
        send(bgt_pkg::CMD_READ, 4, 0);
        while (items_sent < 750) begin
            if (items_sent > 500) idle_pct = 0;
            else if (items_sent > 250) idle_pct = 67;
            grid_session();
        end
        settle();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// File: files.f
hw/rtl/bgt_pkg.sv
hw/rtl/bgt_eval.sv
hw/rtl/binary_grid_thinning.sv
verif/binary_grid_thinning_test.sv
